// ===== rtl/gmds_pkg.sv =====
// gmds_pkg: shared types, codes and constants for the grid maze depth-first solver
// no dependencies; used by every module under rtl

package gmds_pkg;

    // default grid capacity
    localparam int DEFAULT_MAX_CELLS = 256;

    // fixed field widths
    localparam int MODE_W       = 2;
    localparam int CELL_INDEX_W = 8;
    localparam int CODE_W       = 2;
    localparam int MARK_W       = 3;
    localparam int DIR_W        = 3;
    localparam int ROW_WIDTH_W  = 7;
    localparam int CELL_COUNT_W = 9;
    localparam int START_CELL_W = 8;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    // item modes
    localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // cell code with no meaning, stored as a wall
    localparam logic [CODE_W-1:0] CODE_UNUSED = 2'd3;

    // cell marks
    localparam logic [MARK_W-1:0] MARK_OPEN = 3'd0;
    localparam logic [MARK_W-1:0] MARK_WALL = 3'd1;
    localparam logic [MARK_W-1:0] MARK_GOAL = 3'd2;
    localparam logic [MARK_W-1:0] MARK_DEAD = 3'd3;
    localparam logic [MARK_W-1:0] MARK_PATH = 3'd4;
    localparam logic [MARK_W-1:0] MARK_DONE = 3'd5;

    // neighbour probe order
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_ROW_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CELL_COUNT = 2'd1;
    localparam logic [1:0] REG_START_CELL = 2'd2;

    // configuration reset values
    localparam logic [ROW_WIDTH_W-1:0]  RESET_ROW_WIDTH  = 7'd21;
    localparam logic [CELL_COUNT_W-1:0] RESET_CELL_COUNT = 9'd231;
    localparam logic [START_CELL_W-1:0] RESET_START_CELL = 8'd1;

    typedef struct packed {
        logic [ROW_WIDTH_W-1:0]  row_width;
        logic [CELL_COUNT_W-1:0] cell_count;
        logic [START_CELL_W-1:0] start_cell;
    } cfg_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch_in;
        logic wr_cell;
        logic rd_cell;
        logic init_search;
        logic step_probe;
        logic probe_read;
        logic probe_apply;
        logic pop;
        logic pop_load;
        logic path_top;
        logic path_rd;
        logic path_wr;
        logic finish;
        logic load_out;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic probe_ok;
        logic depth_zero;
        logic depth_one;
        logic top_exhausted;
        logic found;
        logic path_more;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/gmds_ram.sv =====
// gmds_ram: generic single write port, single read port ram with registered read
// depends on gmds_pkg for default sizes

module gmds_ram #(
    parameter int WIDTH = gmds_pkg::MARK_W,
    parameter int DEPTH = gmds_pkg::DEFAULT_MAX_CELLS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gmds_ctrl.sv =====
// gmds_ctrl: sequencer for cell writes, reads and the depth-first search
// depends on gmds_pkg for command, status and code definitions

module gmds_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [gmds_pkg::MODE_W-1:0]   mode,
    input  gmds_pkg::dp_status_t          status,
    output logic                          in_ready,
    output gmds_pkg::dp_cmd_t             cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_WR       = 4'd1;
    localparam logic [3:0] ST_RD       = 4'd2;
    localparam logic [3:0] ST_INIT     = 4'd3;
    localparam logic [3:0] ST_STEP     = 4'd4;
    localparam logic [3:0] ST_PROBE    = 4'd5;
    localparam logic [3:0] ST_CHECK    = 4'd6;
    localparam logic [3:0] ST_POPW     = 4'd7;
    localparam logic [3:0] ST_PATH_TOP = 4'd8;
    localparam logic [3:0] ST_PATH_RD  = 4'd9;
    localparam logic [3:0] ST_PATH_WR  = 4'd10;
    localparam logic [3:0] ST_RESP     = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    unique case (mode)
                        gmds_pkg::MODE_WRITE:  state_next = ST_WR;
                        gmds_pkg::MODE_SEARCH: state_next = ST_INIT;
                        gmds_pkg::MODE_READ:   state_next = ST_RD;
                        default:               state_next = ST_RESP;
                    endcase
                end
            end
            ST_WR:
            begin
                cmd.wr_cell = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RD:
            begin
                cmd.rd_cell = 1'b1;
                state_next  = ST_RESP;
            end
            ST_INIT:
            begin
                cmd.init_search = 1'b1;
                state_next      = ST_PROBE;
            end
            ST_STEP:
            begin
                if (status.found)
                begin
                    if (status.depth_zero)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_PATH_TOP;
                    end
                end
                else if (status.depth_zero)
                begin
                    state_next = ST_RESP;
                end
                else if (status.top_exhausted)
                begin
                    cmd.pop    = 1'b1;
                    state_next = status.depth_one ? ST_STEP : ST_POPW;
                end
                else
                begin
                    cmd.step_probe = 1'b1;
                    state_next     = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (status.probe_ok)
                begin
                    cmd.probe_read = 1'b1;
                    state_next     = ST_CHECK;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_CHECK:
            begin
                cmd.probe_apply = 1'b1;
                state_next      = ST_STEP;
            end
            ST_POPW:
            begin
                cmd.pop_load = 1'b1;
                state_next   = ST_STEP;
            end
            ST_PATH_TOP:
            begin
                cmd.path_top = 1'b1;
                state_next   = ST_PATH_RD;
            end
            ST_PATH_RD:
            begin
                if (status.path_more)
                begin
                    cmd.path_rd = 1'b1;
                    state_next  = ST_PATH_WR;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_PATH_WR:
            begin
                cmd.path_wr = 1'b1;
                state_next  = ST_PATH_RD;
            end
            ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/gmds_datapath.sv =====
// gmds_datapath: cell store, search stack, top-of-stack registers and result register
// depends on gmds_pkg and gmds_ram

module gmds_datapath #(
    parameter int MAX_CELLS = gmds_pkg::DEFAULT_MAX_CELLS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gmds_pkg::cfg_t                     cfg,
    input  gmds_pkg::dp_cmd_t                  cmd,
    output gmds_pkg::dp_status_t               status,
    input  logic [gmds_pkg::MODE_W-1:0]        mode,
    input  logic [gmds_pkg::CELL_INDEX_W-1:0]  cell_index,
    input  logic [gmds_pkg::CODE_W-1:0]        cell_code,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic                               path_found,
    output logic [gmds_pkg::MARK_W-1:0]        cell_mark
);

    localparam int CW = $clog2(MAX_CELLS);
    localparam int DW = CW + 1;
    localparam int XW = (CW + 1 > 9) ? CW + 1 : 9;
    localparam int NW = ((CW > gmds_pkg::ROW_WIDTH_W) ? CW : gmds_pkg::ROW_WIDTH_W) + 2;
    localparam int SW = CW + gmds_pkg::DIR_W;

    // latched item
    logic [gmds_pkg::MODE_W-1:0]       mode_reg, mode_next;
    logic [gmds_pkg::CELL_INDEX_W-1:0] idx_reg, idx_next;
    logic [gmds_pkg::CODE_W-1:0]       code_reg, code_next;

    // search state
    logic                         found_reg, found_next;
    logic [DW-1:0]                depth_reg, depth_next;
    logic [CW-1:0]                top_pos_reg, top_pos_next;
    logic [gmds_pkg::DIR_W-1:0]   top_dir_reg, top_dir_next;
    logic [NW-1:0]                probe_pos_reg, probe_pos_next;
    logic [CW-1:0]                sweep_reg, sweep_next;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic                         path_found_reg, path_found_next;
    logic [gmds_pkg::MARK_W-1:0]  cell_mark_reg, cell_mark_next;

    // ram ports
    logic                         cell_we, cell_re;
    logic [CW-1:0]                cell_waddr, cell_raddr;
    logic [gmds_pkg::MARK_W-1:0]  cell_wdata, cell_rdata;
    logic                         stack_we, stack_re;
    logic [CW-1:0]                stack_waddr, stack_raddr;
    logic [SW-1:0]                stack_wdata, stack_rdata;

    logic [XW-1:0]                idx_ext;
    logic                         idx_ok;
    logic [CW-1:0]                idx_addr;
    logic [NW-1:0]                count_ext, usable, base, stride, step_pos;
    logic                         probe_ok;
    logic [CW-1:0]                probe_addr;
    logic [DW-1:0]                depth_m1, depth_m2;
    logic                         push_room, cell_open, cell_goal;
    logic [CW-1:0]                stack_pos;
    logic [gmds_pkg::DIR_W-1:0]   stack_dir;

    // index range check for cell writes and reads
    assign idx_ext  = XW'(idx_reg);
    assign idx_ok   = idx_ext < XW'(MAX_CELLS);
    assign idx_addr = idx_ext[CW-1:0];

    // usable cells are min(cell_count, MAX_CELLS); a negative probe is rejected
    assign count_ext  = NW'(cfg.cell_count);
    assign usable     = (count_ext < NW'(MAX_CELLS)) ? count_ext : NW'(MAX_CELLS);
    assign probe_ok   = !probe_pos_reg[NW-1] && (probe_pos_reg < usable);
    assign probe_addr = probe_pos_reg[CW-1:0];

    // neighbour of the top cell in the current direction
    assign base   = NW'(top_pos_reg);
    assign stride = NW'(cfg.row_width);
    always_comb
    begin
        case (top_dir_reg)
            gmds_pkg::DIR_RIGHT: step_pos = base + NW'(1);
            gmds_pkg::DIR_DOWN:  step_pos = base + stride;
            gmds_pkg::DIR_LEFT:  step_pos = base - NW'(1);
            default:             step_pos = base - stride;
        endcase
    end

    assign depth_m1  = depth_reg - DW'(1);
    assign depth_m2  = depth_reg - DW'(2);
    assign push_room = depth_reg != DW'(MAX_CELLS);
    assign cell_open = cell_rdata == gmds_pkg::MARK_OPEN;
    assign cell_goal = cell_rdata == gmds_pkg::MARK_GOAL;
    assign stack_pos = stack_rdata[SW-1:gmds_pkg::DIR_W];
    assign stack_dir = stack_rdata[gmds_pkg::DIR_W-1:0];

    // cell store port control
    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = idx_addr;
        cell_wdata = gmds_pkg::MARK_OPEN;
        if (cmd.wr_cell && idx_ok)
        begin
            cell_we    = 1'b1;
            cell_wdata = (code_reg == gmds_pkg::CODE_UNUSED) ? gmds_pkg::MARK_WALL
                                                               : {1'b0, code_reg};
        end
        else if (cmd.probe_apply && (cell_open || cell_goal))
        begin
            cell_we    = 1'b1;
            cell_waddr = probe_addr;
            cell_wdata = cell_open ? gmds_pkg::MARK_DEAD : gmds_pkg::MARK_DONE;
        end
        else if (cmd.path_top)
        begin
            cell_we    = 1'b1;
            cell_waddr = top_pos_reg;
            cell_wdata = gmds_pkg::MARK_PATH;
        end
        else if (cmd.path_wr)
        begin
            cell_we    = 1'b1;
            cell_waddr = stack_pos;
            cell_wdata = gmds_pkg::MARK_PATH;
        end
    end

    assign cell_re    = (cmd.rd_cell && idx_ok) || cmd.probe_read;
    assign cell_raddr = cmd.probe_read ? probe_addr : idx_addr;

    // stack port control; the top entry lives in registers, the rest below it in ram
    assign stack_we    = cmd.probe_apply && cell_open && push_room && (depth_reg != '0);
    assign stack_waddr = depth_m1[CW-1:0];
    assign stack_wdata = {top_pos_reg, top_dir_reg};
    assign stack_re    = (cmd.pop && (depth_reg > DW'(1))) || cmd.path_rd;
    assign stack_raddr = cmd.path_rd ? sweep_reg : depth_m2[CW-1:0];

    gmds_ram #(
        .WIDTH (gmds_pkg::MARK_W),
        .DEPTH (MAX_CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    gmds_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_CELLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .re    (stack_re),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // next values of the datapath registers
    always_comb
    begin
        mode_next       = mode_reg;
        idx_next        = idx_reg;
        code_next       = code_reg;
        found_next      = found_reg;
        depth_next      = depth_reg;
        top_pos_next    = top_pos_reg;
        top_dir_next    = top_dir_reg;
        probe_pos_next  = probe_pos_reg;
        sweep_next      = sweep_reg;
        out_valid_next  = out_valid_reg;
        path_found_next = path_found_reg;
        cell_mark_next  = cell_mark_reg;

        if (cmd.latch_in)
        begin
            mode_next = mode;
            idx_next  = cell_index;
            code_next = cell_code;
        end

        if (cmd.init_search)
        begin
            found_next     = 1'b0;
            depth_next     = '0;
            probe_pos_next = NW'(cfg.start_cell);
        end

        if (cmd.step_probe)
        begin
            probe_pos_next = step_pos;
            top_dir_next   = top_dir_reg + gmds_pkg::DIR_W'(1);
        end

        // enter an open cell, or finish on a goal
        if (cmd.probe_apply)
        begin
            if (cell_open && push_room)
            begin
                top_pos_next = probe_addr;
                top_dir_next = gmds_pkg::DIR_RIGHT;
                depth_next   = depth_reg + DW'(1);
            end
            else if (cell_goal)
            begin
                found_next = 1'b1;
            end
        end

        if (cmd.pop)
        begin
            depth_next = depth_m1;
        end

        if (cmd.pop_load)
        begin
            top_pos_next = stack_pos;
            top_dir_next = stack_dir;
        end

        if (cmd.path_top)
        begin
            sweep_next = '0;
        end

        if (cmd.path_wr)
        begin
            sweep_next = sweep_reg + CW'(1);
        end

        if (cmd.finish)
        begin
            depth_next = '0;
        end

        // result register, freed by the downstream transaction
        if (cmd.load_out)
        begin
            out_valid_next  = 1'b1;
            path_found_next = found_reg;
            cell_mark_next  = ((mode_reg == gmds_pkg::MODE_READ) && idx_ok) ? cell_rdata
                                                                              : gmds_pkg::MARK_OPEN;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg     <= found_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        idx_reg        <= idx_next;
        code_reg       <= code_next;
        top_pos_reg    <= top_pos_next;
        top_dir_reg    <= top_dir_next;
        probe_pos_reg  <= probe_pos_next;
        sweep_reg      <= sweep_next;
        path_found_reg <= path_found_next;
        cell_mark_reg  <= cell_mark_next;
    end

    // status to the controller
    assign status.probe_ok      = probe_ok;
    assign status.depth_zero    = depth_reg == '0;
    assign status.depth_one     = depth_reg == DW'(1);
    assign status.top_exhausted = top_dir_reg == gmds_pkg::DIR_DONE;
    assign status.found         = found_reg;
    assign status.path_more     = (DW'(sweep_reg) + DW'(1)) < depth_reg;
    assign status.out_free      = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign path_found = path_found_reg;
    assign cell_mark  = cell_mark_reg;

    // the cell store is only probed inside the grid
    a_probe_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_read |-> probe_ok)
        else $error("cell probe outside the grid");

    // a pop only takes an exhausted entry off a non-empty stack
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (depth_reg != '0) && (top_dir_reg == gmds_pkg::DIR_DONE))
        else $error("pop of an empty stack or an unfinished entry");

    // path marking only follows a reached goal
    a_path_after_goal: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.path_top || cmd.path_wr) |-> found_reg)
        else $error("path marked without a goal");

    // stack depth never passes the capacity
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(MAX_CELLS))
        else $error("stack depth beyond capacity");

endmodule

// ===== rtl/grid_maze_dfs_solver.sv =====
// grid_maze_dfs_solver: top level with apb configuration registers, controller and datapath
// depends on gmds_pkg, gmds_ctrl, gmds_datapath and gmds_ram
//
//   channel   handshake                  payload
//   in        in_valid / in_ready        mode, cell_index, cell_code
//   out       out_valid / out_ready      path_found, cell_mark
//   config    psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// a cell write or a read goes from idle through its write or read state and the response
// state into the result register (an unused mode goes straight there); the next item is
// taken once back in idle. a search runs step, probe and check per probe inside the grid
// (check waits on the registered read of the cell store), step and probe outside it, step
// and popw per stack pop (step alone for the last), then path_top and path_rd, path_wr per
// further path cell. rst_n clears the controller, stack depth, found flag and result valid;
// cell contents are undefined until written. a new item is taken while a result waits; the
// block stalls at its result only if the previous result has not yet been taken.

module grid_maze_dfs_solver #(
    parameter int MAX_CELLS = gmds_pkg::DEFAULT_MAX_CELLS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [gmds_pkg::MODE_W-1:0]         mode,
    input  logic [gmds_pkg::CELL_INDEX_W-1:0]   cell_index,
    input  logic [gmds_pkg::CODE_W-1:0]         cell_code,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                path_found,
    output logic [gmds_pkg::MARK_W-1:0]         cell_mark,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gmds_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gmds_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gmds_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    gmds_pkg::cfg_t       cfg_reg;
    gmds_pkg::cfg_t       cfg_next;
    gmds_pkg::dp_cmd_t    cmd;
    gmds_pkg::dp_status_t status;
    logic                 cfg_write;
    logic [1:0]           reg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    // configuration register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                gmds_pkg::REG_ROW_WIDTH:
                    cfg_next.row_width  = pwdata[gmds_pkg::ROW_WIDTH_W-1:0];
                gmds_pkg::REG_CELL_COUNT:
                    cfg_next.cell_count = pwdata[gmds_pkg::CELL_COUNT_W-1:0];
                gmds_pkg::REG_START_CELL:
                    cfg_next.start_cell = pwdata[gmds_pkg::START_CELL_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // configuration read mux
    always_comb
    begin
        unique case (reg_index)
            gmds_pkg::REG_ROW_WIDTH:  prdata = gmds_pkg::APB_DATA_W'(cfg_reg.row_width);
            gmds_pkg::REG_CELL_COUNT: prdata = gmds_pkg::APB_DATA_W'(cfg_reg.cell_count);
            gmds_pkg::REG_START_CELL: prdata = gmds_pkg::APB_DATA_W'(cfg_reg.start_cell);
            default:                  prdata = '0;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width  <= gmds_pkg::RESET_ROW_WIDTH;
            cfg_reg.cell_count <= gmds_pkg::RESET_CELL_COUNT;
            cfg_reg.start_cell <= gmds_pkg::RESET_START_CELL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gmds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    gmds_datapath #(
        .MAX_CELLS (MAX_CELLS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .status     (status),
        .mode       (mode),
        .cell_index (cell_index),
        .cell_code  (cell_code),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .path_found (path_found),
        .cell_mark  (cell_mark)
    );

endmodule

// ===== tb/maze_solve_checker.sv =====
// maze_solve_checker: watches the item, result and register channels of grid_maze_dfs_solver,
// keeps its own copy of the grid and settings, predicts every result and compares it
// depends on gmds_pkg
`timescale 1ns / 1ps

module maze_solve_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [gmds_pkg::MODE_W-1:0]         mode,
    input  logic [gmds_pkg::CELL_INDEX_W-1:0]   cell_index,
    input  logic [gmds_pkg::CODE_W-1:0]         cell_code,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                path_found,
    input  logic [gmds_pkg::MARK_W-1:0]         cell_mark,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gmds_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gmds_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic [gmds_pkg::APB_DATA_W-1:0]     prdata,
    input  logic                                pready,
    output int                                  pending,
    output int                                  fail_count
);

    import gmds_pkg::*;

    localparam int MAX_CELLS = DEFAULT_MAX_CELLS;

    typedef struct packed {
        logic              path_found;
        logic [MARK_W-1:0] cell_mark;
    } maze_result_t;

    // settings as last written over the register port
    logic [ROW_WIDTH_W-1:0]  row_width_q;
    logic [CELL_COUNT_W-1:0] cell_count_q;
    logic [START_CELL_W-1:0] start_cell_q;

    // grid copy and the search trail (cell plus next direction to try)
    logic [MARK_W-1:0] grid_marks [MAX_CELLS];
    int                trail_cell [MAX_CELLS];
    logic [DIR_W-1:0]  trail_dir  [MAX_CELLS];
    int                trail_depth;
    logic              goal_hit;

    maze_result_t expected_results [$];

    function automatic int grid_cells();
        return (int'(cell_count_q) < MAX_CELLS) ? int'(cell_count_q) : MAX_CELLS;
    endfunction

    // enter an open cell, or finish on a goal; anything off the grid is ignored
    function automatic void enter_cell(input int pos);
        if (pos < 0 || pos >= grid_cells())
            return;
        if (grid_marks[pos] == MARK_OPEN)
        begin
            grid_marks[pos] = MARK_DEAD;
            if (trail_depth < MAX_CELLS)
            begin
                trail_cell[trail_depth] = pos;
                trail_dir[trail_depth]  = DIR_RIGHT;
                trail_depth++;
            end
        end
        else if (grid_marks[pos] == MARK_GOAL)
        begin
            grid_marks[pos] = MARK_DONE;
            goal_hit = 1'b1;
        end
    endfunction

    // depth-first walk: right, down, left, up from the cell on top of the trail
    function automatic void solve_maze();
        int               top;
        int               next;
        logic [DIR_W-1:0] step;
        goal_hit    = 1'b0;
        trail_depth = 0;
        enter_cell(int'(start_cell_q));
        while (trail_depth > 0 && !goal_hit)
        begin
            top = trail_depth - 1;
            if (trail_dir[top] >= DIR_DONE)
                trail_depth--;
            else
            begin
                step = trail_dir[top];
                trail_dir[top] = trail_dir[top] + 1'b1;
                case (step)
                    DIR_RIGHT: next = trail_cell[top] + 1;
                    DIR_DOWN:  next = trail_cell[top] + int'(row_width_q);
                    DIR_LEFT:  next = trail_cell[top] - 1;
                    default:   next = trail_cell[top] - int'(row_width_q);
                endcase
                enter_cell(next);
            end
        end
        // whatever is still on the trail is the found path
        if (goal_hit)
            for (int k = 0; k < trail_depth; k++)
                grid_marks[trail_cell[k]] = MARK_PATH;
        trail_depth = 0;
    endfunction

    function automatic maze_result_t apply_item(input logic [MODE_W-1:0] m,
                                                input logic [CELL_INDEX_W-1:0] idx,
                                                input logic [CODE_W-1:0] code);
        maze_result_t r;
        r.cell_mark = MARK_OPEN;
        case (m)
            MODE_WRITE:  grid_marks[idx] = (code == CODE_UNUSED) ? MARK_WALL : {1'b0, code};
            MODE_SEARCH: solve_maze();
            MODE_READ:   r.cell_mark = grid_marks[idx];
            default:     ;
        endcase
        r.path_found = goal_hit;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        maze_result_t want;
        logic [APB_DATA_W-1:0] reg_value;
        if (!rst_n)
        begin
            row_width_q  = RESET_ROW_WIDTH;
            cell_count_q = RESET_CELL_COUNT;
            start_cell_q = RESET_START_CELL;
            for (int i = 0; i < MAX_CELLS; i++)
                grid_marks[i] = MARK_OPEN;
            trail_depth = 0;
            goal_hit    = 1'b0;
            expected_results.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            // item transaction: predict its result
            if (in_valid && in_ready)
                expected_results.push_back(apply_item(mode, cell_index, cell_code));

            // result transaction: compare with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no item waiting: path_found %0d, cell_mark %0d",
                           path_found, cell_mark);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (path_found !== want.path_found)
                    begin
                        $error("path_found: expected %0d, got %0d", want.path_found, path_found);
                        fail_count++;
                    end
                    if (cell_mark !== want.cell_mark)
                    begin
                        $error("cell_mark: expected %0d, got %0d", want.cell_mark, cell_mark);
                        fail_count++;
                    end
                end
            end

            // register port: track writes, check read data
            if (psel && penable && pready)
            begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_ROW_WIDTH:  reg_value = APB_DATA_W'(row_width_q);
                    REG_CELL_COUNT: reg_value = APB_DATA_W'(cell_count_q);
                    REG_START_CELL: reg_value = APB_DATA_W'(start_cell_q);
                    default:        reg_value = '0;
                endcase
                if (pwrite)
                begin
                    case (paddr[APB_ADDR_W-1:2])
                        REG_ROW_WIDTH:  row_width_q  = pwdata[ROW_WIDTH_W-1:0];
                        REG_CELL_COUNT: cell_count_q = pwdata[CELL_COUNT_W-1:0];
                        REG_START_CELL: start_cell_q = pwdata[START_CELL_W-1:0];
                        default:        ;
                    endcase
                end
                else if (prdata !== reg_value)
                begin
                    $error("prdata: expected %0d, got %0d", reg_value, prdata);
                    fail_count++;
                end
            end

            pending = expected_results.size();
        end
    end

endmodule

// ===== tb/tb_grid_maze_dfs_solver.sv =====
// tb_grid_maze_dfs_solver: stimulus and verdict for grid_maze_dfs_solver
// loads mazes, runs searches and reads marks back; depends on gmds_pkg, grid_maze_dfs_solver and maze_solve_checker
`timescale 1ns / 1ps

module tb_grid_maze_dfs_solver;

    import gmds_pkg::*;

    localparam int GRID_MAX     = DEFAULT_MAX_CELLS;
    localparam int ITEM_TARGET  = 580;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 4;
    localparam int END_SETTLE   = 16;

    // cell codes and the mode with no meaning
    localparam logic [CODE_W-1:0] CODE_OPEN   = 2'd0;
    localparam logic [CODE_W-1:0] CODE_WALL   = 2'd1;
    localparam logic [CODE_W-1:0] CODE_GOAL   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_ready;
    logic [MODE_W-1:0]       mode       = MODE_WRITE;
    logic [CELL_INDEX_W-1:0] cell_index = '0;
    logic [CODE_W-1:0]       cell_code  = CODE_OPEN;
    logic                    out_valid;
    logic                    out_ready  = 1'b0;
    logic                    path_found;
    logic [MARK_W-1:0]       cell_mark;
    logic                    psel       = 1'b0;
    logic                    penable    = 1'b0;
    logic                    pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr      = '0;
    logic [APB_DATA_W-1:0]   pwdata     = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    int pending;
    int fail_count;

    // stimulus bookkeeping
    bit cell_loaded [GRID_MAX];
    int shadow_cell_count = RESET_CELL_COUNT;
    int job_count         = 0;
    bit gappy             = 1'b1;
    int sink_wait         = 0;
    int cycle_count       = 0;

    always #1 clk = ~clk;

    grid_maze_dfs_solver u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .cell_index (cell_index),
        .cell_code  (cell_code),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .path_found (path_found),
        .cell_mark  (cell_mark),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    maze_solve_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .cell_index (cell_index),
        .cell_code  (cell_code),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .path_found (path_found),
        .cell_mark  (cell_mark),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // result side: a random stall of out_ready after each transaction while gappy is set
    always @(posedge clk)
    begin : result_sink
        int hold;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_wait <= 0;
        end
        else if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1;
            out_ready <= (sink_wait == 1);
        end
        else if (out_valid && out_ready)
        begin
            hold = gappy ? $urandom_range(0, 4) : 0;
            sink_wait <= hold;
            out_ready <= (hold == 0);
        end
        else
            out_ready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // one item transaction, after a random gap when gappy is set
    task automatic send_item(input logic [MODE_W-1:0] m, input int idx,
                             input logic [CODE_W-1:0] code);
        int gap;
        gap = gappy ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        cell_index <= idx[CELL_INDEX_W-1:0];
        cell_code  <= code;
        do @(posedge clk); while (!in_ready);
        if (m == MODE_WRITE)
            cell_loaded[idx] = 1'b1;
        if (m != MODE_UNUSED)
            job_count++;
    endtask

    // hold off until every predicted result has been taken
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (settle) @(posedge clk);
    endtask

    // one register transfer: setup, access, then back to idle
    task automatic reg_access(input bit is_write, input logic [1:0] idx,
                              input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write all three settings with junk above the field, then read them back
    task automatic set_config(input int rw, input int cc, input int st);
        reg_access(1'b1, REG_ROW_WIDTH,  ($urandom() << ROW_WIDTH_W)  | rw);
        reg_access(1'b1, REG_CELL_COUNT, ($urandom() << CELL_COUNT_W) | cc);
        reg_access(1'b1, REG_START_CELL, ($urandom() << START_CELL_W) | st);
        reg_access(1'b0, REG_ROW_WIDTH,  '0);
        reg_access(1'b0, REG_CELL_COUNT, '0);
        reg_access(1'b0, REG_START_CELL, '0);
        shadow_cell_count = cc;
    endtask

    function automatic int grid_cells();
        return (shadow_cell_count < GRID_MAX) ? shadow_cell_count : GRID_MAX;
    endfunction

    function automatic logic [CODE_W-1:0] random_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return CODE_OPEN;
        else if (r < 88)
            return CODE_WALL;
        else if (r < 96)
            return CODE_GOAL;
        return CODE_UNUSED;
    endfunction

    // a search may probe any cell of the grid, so every one must be loaded first
    task automatic search_item();
        for (int i = 0; i < grid_cells(); i++)
            if (!cell_loaded[i])
                send_item(MODE_WRITE, i, random_code());
        send_item(MODE_SEARCH, $urandom_range(0, GRID_MAX - 1), CODE_W'($urandom_range(0, 3)));
    endtask

    // read back a cell that has been loaded, mostly inside the grid
    task automatic read_item();
        int idx;
        if (grid_cells() > 0 && $urandom_range(0, 3) != 0)
            idx = $urandom_range(0, grid_cells() - 1);
        else
            idx = $urandom_range(0, GRID_MAX - 1);
        while (!cell_loaded[idx])
            idx = $urandom_range(0, GRID_MAX - 1);
        send_item(MODE_READ, idx, CODE_W'($urandom_range(0, 3)));
    endtask

    // one maze: pick settings, load the grid, plant goals, search and poke at it
    task automatic maze_round();
        int rw;
        int cc;
        int st;
        int lim;
        int r;
        gappy = ($urandom_range(0, 3) != 0);
        drain(SETTLE);
        case ($urandom_range(0, 9))
            0:       rw = 0;
            1:       rw = 2;
            2:       rw = 64;
            3:       rw = 127;
            default: rw = $urandom_range(2, 16);
        endcase
        case ($urandom_range(0, 11))
            0:       cc = 256;
            1:       cc = 511;
            2:       cc = 0;
            3:       cc = 1;
            4:       cc = $urandom_range(100, 255);
            default: cc = $urandom_range(4, 48);
        endcase
        lim = (cc < GRID_MAX) ? cc : GRID_MAX;
        case ($urandom_range(0, 9))
            0:       st = 255;
            1:       st = $urandom_range(0, 255);
            default: st = (lim > 0) ? $urandom_range(0, lim - 1) : 0;
        endcase
        set_config(rw, cc, st);

        // mostly a fresh grid; otherwise old marks stay for a repeated search
        if ($urandom_range(0, 3) != 0)
            for (int i = 0; i < lim; i++)
                send_item(MODE_WRITE, i, random_code());
        if (lim > 0)
            repeat ($urandom_range(1, 2))
                send_item(MODE_WRITE, $urandom_range(0, lim - 1), CODE_GOAL);
        if (st < lim && $urandom_range(0, 3) != 0)
            send_item(MODE_WRITE, st, CODE_OPEN);
        search_item();

        repeat ($urandom_range(4, 12))
        begin
            r = $urandom_range(0, 19);
            if (r < 3)
                search_item();
            else if (r < 12)
                read_item();
            else if (r < 17)
                send_item(MODE_WRITE,
                          (lim > 0 && r < 15) ? $urandom_range(0, lim - 1)
                                              : $urandom_range(0, GRID_MAX - 1),
                          random_code());
            else if (r == 17)
                send_item(MODE_UNUSED, $urandom_range(0, GRID_MAX - 1),
                          CODE_W'($urandom_range(0, 3)));
            else
                drain(SETTLE);
        end
    endtask

    initial
    begin
        logic [CODE_W-1:0] code;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hand-built 4x4 maze with one winding path from the corner to the goal
        set_config(4, 16, 0);
        for (int i = 0; i < 16; i++)
        begin
            case (i)
                2, 6, 11, 12, 13: code = CODE_WALL;
                4:                code = CODE_UNUSED;
                15:               code = CODE_GOAL;
                default:          code = CODE_OPEN;
            endcase
            send_item(MODE_WRITE, i, code);
        end
        search_item();
        send_item(MODE_READ, 15, CODE_OPEN);
        send_item(MODE_READ, 0, CODE_OPEN);
        send_item(MODE_READ, 4, CODE_OPEN);
        send_item(MODE_READ, 14, CODE_OPEN);
        send_item(MODE_READ, 3, CODE_OPEN);
        // start is now a dead end, so a second search finds nothing
        search_item();
        send_item(MODE_UNUSED, 255, CODE_UNUSED);
        send_item(MODE_WRITE, 3, CODE_GOAL);

        // start on a goal
        drain(SETTLE);
        set_config(4, 16, 3);
        search_item();
        send_item(MODE_READ, 3, CODE_OPEN);

        // start outside the grid
        drain(SETTLE);
        set_config(4, 16, 200);
        search_item();

        // empty grid rejects every cell
        drain(SETTLE);
        set_config(0, 0, 0);
        search_item();

        // start on a wall
        drain(SETTLE);
        set_config(4, 16, 2);
        search_item();
        send_item(MODE_READ, 2, CODE_OPEN);

        // random mazes
        while (job_count < ITEM_TARGET)
            maze_round();

        gappy = 1'b1;
        drain(END_SETTLE);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== grid_maze_dfs_solver.f =====
rtl/gmds_pkg.sv
rtl/gmds_ram.sv
rtl/gmds_ctrl.sv
rtl/gmds_datapath.sv
rtl/grid_maze_dfs_solver.sv
tb/maze_solve_checker.sv
tb/tb_grid_maze_dfs_solver.sv
